### rtl/emrf_pkg.sv
package emrf_pkg;

    // Channel scan
    localparam int CHANNEL_COUNT = 10;
    localparam int CHAN_W        = $clog2(CHANNEL_COUNT);

    // Field widths
    localparam int ECHO_W   = 14;
    localparam int DIST_W   = 18;
    localparam int WEIGHT_W = 9;
    localparam int SCALE_W  = 24;
    localparam int NODE_W   = 6;
    localparam int PAIR_W   = 5;
    localparam int IDENT_W  = NODE_W + PAIR_W;

    // Arithmetic
    localparam int PROD_W     = ECHO_W + SCALE_W;
    localparam int FRAC_SHIFT = 16;
    localparam int BLEND_W    = 26;
    localparam logic [DIST_W-1:0]   DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);
    localparam logic [PROD_W:0]     RANGE_HALF = (PROD_W+1)'(1) << (FRAC_SHIFT - 1);
    localparam logic [BLEND_W-1:0]  BLEND_HALF = BLEND_W'(128);
    localparam logic [PAIR_W-1:0]   PAIR_BASE  = PAIR_W'(2);

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLEND_WEIGHT     = 3'd0,
        REG_RANGE_SCALE      = 3'd1,
        REG_NO_ECHO_DISTANCE = 3'd2,
        REG_NODE_NUMBER      = 3'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [WEIGHT_W-1:0] blend_weight;
        logic [SCALE_W-1:0]  range_scale;
        logic [DIST_W-1:0]   no_echo_distance;
        logic [NODE_W-1:0]   node_number;
    } cfg_t;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [ECHO_W-1:0] echo_width_us;
        logic              first;
        logic              odd;
    } queue_entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCALE,
        B_RANGE,
        B_MULT,
        B_DONE
    } back_state_t;

endpackage

### rtl/emrf_in_if.sv
interface emrf_in_if import emrf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ECHO_W-1:0] echo_width_us;

    modport source (output valid, output echo_width_us, input ready);
    modport sink (input valid, input echo_width_us, output ready);
endinterface

### rtl/emrf_out_if.sv
interface emrf_out_if import emrf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDENT_W-1:0] frame_ident;
    logic [DIST_W-1:0]  even_distance;
    logic [DIST_W-1:0]  odd_distance;

    modport source (output valid, output frame_ident, output even_distance,
                    output odd_distance, input ready);
    modport sink (input valid, input frame_ident, input even_distance,
                  input odd_distance, output ready);
endinterface

### rtl/emrf_cfg_if.sv
interface emrf_cfg_if import emrf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/emrf_ram.sv
module emrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/emrf_queue.sv
module emrf_queue import emrf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head_entry,
    output logic         full,
    output logic         not_empty
);

    queue_entry_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("item pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("item popped from an empty queue");

endmodule

### rtl/emrf_front.sv
module emrf_front import emrf_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    emrf_in_if.sink       echo,
    input  logic          q_full,
    output logic          q_push,
    output queue_entry_t  q_entry
);

    logic [CHAN_W-1:0]        scan_reg;
    logic [CHAN_W-1:0]        chan;
    logic [CHANNEL_COUNT-1:0] seeded_reg;

    // A scan value past the last channel is treated as channel zero.
    assign chan = ({1'b0, scan_reg} >= (CHAN_W+1)'(CHANNEL_COUNT)) ? '0 : scan_reg;

    assign echo.ready = !q_full;
    assign q_push     = echo.valid && !q_full;

    always_comb
    begin
        q_entry.chan          = chan;
        q_entry.echo_width_us = echo.echo_width_us;
        q_entry.first         = !seeded_reg[chan];
        q_entry.odd           = chan[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= '0;
            seeded_reg <= '0;
        end
        else if (q_push)
        begin
            seeded_reg[chan] <= 1'b1;
            scan_reg <= (chan == CHAN_W'(CHANNEL_COUNT - 1)) ? '0 : chan + CHAN_W'(1);
        end
    end

endmodule

### rtl/emrf_back.sv
module emrf_back import emrf_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          q_not_empty,
    input  queue_entry_t  q_entry,
    output logic          q_pop,
    emrf_out_if.source    frame
);

    back_state_t        state_reg;
    back_state_t        state_next;
    queue_entry_t       work_reg;
    logic [PROD_W-1:0]  product_reg;
    logic [DIST_W-1:0]  raw_reg;
    logic [BLEND_W-1:0] new_part_reg;
    logic [BLEND_W-1:0] old_part_reg;
    logic [DIST_W-1:0]  even_hold_reg;

    logic               out_valid_reg;
    logic [IDENT_W-1:0] frame_ident_reg;
    logic [DIST_W-1:0]  even_distance_reg;
    logic [DIST_W-1:0]  odd_distance_reg;

    logic                ram_wr_en;
    logic                load_out;
    logic [DIST_W-1:0]   old_value;
    logic [PROD_W:0]     rounded;
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] weight_rest;
    logic [BLEND_W-1:0]  blend_sum;
    logic [DIST_W-1:0]   result;

    // Filtered distance per channel, read when an item is taken from the queue.
    emrf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (CHANNEL_COUNT)
    ) u_range_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (work_reg.chan),
        .wr_data (result),
        .rd_en   (q_pop),
        .rd_addr (q_entry.chan),
        .rd_data (old_value)
    );

    assign rounded     = {1'b0, product_reg} + RANGE_HALF;
    assign weight      = (cfg.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.blend_weight;
    assign weight_rest = WEIGHT_ONE - weight;
    assign blend_sum   = new_part_reg + old_part_reg + BLEND_HALF;
    assign result      = work_reg.first ? raw_reg : blend_sum[BLEND_W-1 -: DIST_W];

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        ram_wr_en  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_SCALE;
                end
            end
            B_SCALE: state_next = B_RANGE;
            B_RANGE: state_next = B_MULT;
            B_MULT:  state_next = B_DONE;
            B_DONE:
            begin
                if (!work_reg.odd || !out_valid_reg || frame.ready)
                begin
                    ram_wr_en = 1'b1;
                    load_out  = work_reg.odd;
                    if (q_not_empty)
                    begin
                        q_pop      = 1'b1;
                        state_next = B_SCALE;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_entry;
        end
        if (state_reg == B_SCALE)
        begin
            product_reg <= PROD_W'(work_reg.echo_width_us) * PROD_W'(cfg.range_scale);
        end
        if (state_reg == B_RANGE)
        begin
            if (work_reg.echo_width_us == '0)
            begin
                raw_reg <= cfg.no_echo_distance;
            end
            else if (rounded[PROD_W:FRAC_SHIFT] > (PROD_W+1-FRAC_SHIFT)'(DIST_MAX))
            begin
                raw_reg <= DIST_MAX;
            end
            else
            begin
                raw_reg <= rounded[FRAC_SHIFT +: DIST_W];
            end
        end
        if (state_reg == B_MULT)
        begin
            new_part_reg <= BLEND_W'(weight) * BLEND_W'(raw_reg);
            old_part_reg <= BLEND_W'(weight_rest) * BLEND_W'(old_value);
        end
        if (ram_wr_en && !work_reg.odd)
        begin
            even_hold_reg <= result;
        end
        if (load_out)
        begin
            frame_ident_reg   <= {cfg.node_number,
                                  PAIR_BASE + PAIR_W'(work_reg.chan >> 1)};
            even_distance_reg <= even_hold_reg;
            odd_distance_reg  <= result;
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_ident   = frame_ident_reg;
    assign frame.even_distance = even_distance_reg;
    assign frame.odd_distance  = odd_distance_reg;

    a_frame_after_odd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_DONE) && $past(work_reg.odd))
        else $error("frame raised without a finished odd channel");

    a_scale_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SCALE) |-> $past(q_pop))
        else $error("scaling started without an item from the queue");

    a_write_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == B_DONE))
        else $error("filter store written outside the final step");

endmodule

### rtl/multichannel_echo_range_filter.sv
// Items pass the queue, then the four steps of the back end (scale multiply,
// round and saturate, two blend multiplies, sum and write back), one at a time.
// Each odd channel then loads its pair's frame, and a pending frame stalls that step.
// The front accepts up to two items ahead into its queue while the back end works.
// Reset (rst_n, asynchronous, active low) restores register defaults, the scan
// channel and the seeded flags; the filter store keeps no reset value.
module multichannel_echo_range_filter import emrf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    emrf_in_if.sink    echo,
    emrf_out_if.source frame,
    emrf_cfg_if.sink   cfg
);

    // Configuration registers. Writes are taken in any cycle; a write to an
    // index past the last register is dropped without effect.
    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_weight     <= WEIGHT_W'(77);
            cfg_reg.range_scale      <= SCALE_W'(736586);
            cfg_reg.no_echo_distance <= DIST_W'(196608);
            cfg_reg.node_number      <= NODE_W'(26);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BLEND_WEIGHT:     cfg_reg.blend_weight     <= cfg.data[WEIGHT_W-1:0];
                REG_RANGE_SCALE:      cfg_reg.range_scale      <= cfg.data[SCALE_W-1:0];
                REG_NO_ECHO_DISTANCE: cfg_reg.no_echo_distance <= cfg.data[DIST_W-1:0];
                REG_NODE_NUMBER:      cfg_reg.node_number      <= cfg.data[NODE_W-1:0];
                default:              ;
            endcase
        end
    end

    // The front tags each item with its scan channel and whether that channel
    // has been seeded yet. The queue decouples it from the arithmetic.
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_not_empty;
    queue_entry_t push_entry;
    queue_entry_t head_entry;

    emrf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .echo    (echo),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    emrf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .full       (q_full),
        .not_empty  (q_not_empty)
    );

    // The back end converts the echo width to a distance, blends it into the
    // channel's moving average and, after each odd channel, loads the output
    // register with the pair's frame; a pending frame stalls it, then the front.
    emrf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_entry     (head_entry),
        .q_pop       (q_pop),
        .frame       (frame)
    );

endmodule

### sim/testbench.sv
module testbench import emrf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // The blend weight is in units of 1/256, so the weighted sum drops eight bits.
    localparam int WEIGHT_SHIFT = 8;

    // Register values that the block holds after reset.
    localparam logic [WEIGHT_W-1:0] RESET_WEIGHT   = WEIGHT_W'(77);
    localparam logic [SCALE_W-1:0]  RESET_SCALE    = SCALE_W'(736586);
    localparam logic [DIST_W-1:0]   RESET_NO_ECHO  = DIST_W'(196608);
    localparam logic [NODE_W-1:0]   RESET_NODE     = NODE_W'(26);

    // Indexes past the last register are accepted by the port and ignored.
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNMAPPED_REG = CFG_INDEX_W'(REG_NODE_NUMBER) + 1'b1;

    localparam logic [ECHO_W-1:0]  ECHO_MAX = {ECHO_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
    localparam logic [NODE_W-1:0]  NODE_MAX = {NODE_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    // The random part is split into phases, each with its own register setting.
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 275;

    // An even-channel item produces no frame, so once the last expected frame
    // has arrived the block may still be busy with up to three more items
    // (one in the back end, two in the queue).
    localparam int SETTLE_CYCLES = 24;

    // Generous ceiling on the whole run. The slowest correct run (every gap at
    // its longest and the receiver stalled hard) stays well below this.
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [IDENT_W-1:0] ident;
        logic [DIST_W-1:0]  even_dist;
        logic [DIST_W-1:0]  odd_dist;
    } frame_fields_t;

    // Tracks the register file, the scan position and the per-channel moving
    // averages, and keeps the frames that the block still owes.
    class echo_frame_tracker;
        logic [WEIGHT_W-1:0] weight;
        logic [SCALE_W-1:0]  scale;
        logic [DIST_W-1:0]   no_echo_dist;
        logic [NODE_W-1:0]   node;
        int unsigned         chan;
        logic [DIST_W-1:0]   avg_dist[CHANNEL_COUNT];
        bit                  seeded[CHANNEL_COUNT];
        frame_fields_t       pending_frames[$];
        int                  errors;

        function new();
            weight       = RESET_WEIGHT;
            scale        = RESET_SCALE;
            no_echo_dist = RESET_NO_ECHO;
            node         = RESET_NODE;
            chan         = 0;
            errors       = 0;
            foreach (seeded[i])
            begin
                seeded[i]   = 1'b0;
                avg_dist[i] = '0;
            end
        endfunction

        function void take_register(logic [CFG_INDEX_W-1:0] index,
                                    logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_BLEND_WEIGHT:     weight       = data[WEIGHT_W-1:0];
                REG_RANGE_SCALE:      scale        = data[SCALE_W-1:0];
                REG_NO_ECHO_DISTANCE: no_echo_dist = data[DIST_W-1:0];
                REG_NODE_NUMBER:      node         = data[NODE_W-1:0];
                default: ;
            endcase
        endfunction

        // Width in microseconds to Q16 meters, rounded half up and saturated.
        function logic [DIST_W-1:0] width_to_dist(logic [ECHO_W-1:0] width);
            longint unsigned product;
            if (width == '0)
                return no_echo_dist;
            product = longint'(width) * longint'(scale) + longint'(RANGE_HALF);
            product = product >> FRAC_SHIFT;
            if (product > longint'(DIST_MAX))
                return DIST_MAX;
            return product[DIST_W-1:0];
        endfunction

        function logic [DIST_W-1:0] blend_dist(logic [DIST_W-1:0] old_avg,
                                               logic [DIST_W-1:0] sample);
            longint unsigned wt;
            longint unsigned total;
            // Weights above one full unit act as one full unit.
            wt = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
            total = wt * longint'(sample) + (longint'(WEIGHT_ONE) - wt) * longint'(old_avg)
                    + longint'(BLEND_HALF);
            total = total >> WEIGHT_SHIFT;
            return total[DIST_W-1:0];
        endfunction

        function void take_echo(logic [ECHO_W-1:0] width);
            logic [DIST_W-1:0] sample;
            frame_fields_t     frame_exp;
            sample = width_to_dist(width);
            if (!seeded[chan])
            begin
                avg_dist[chan] = sample;
                seeded[chan]   = 1'b1;
            end
            else
            begin
                avg_dist[chan] = blend_dist(avg_dist[chan], sample);
            end
            if (chan % 2 == 1)
            begin
                frame_exp.ident     = {node, PAIR_W'(PAIR_BASE + chan / 2)};
                frame_exp.even_dist = avg_dist[chan - 1];
                frame_exp.odd_dist  = avg_dist[chan];
                pending_frames.push_back(frame_exp);
            end
            chan = (chan + 1 >= CHANNEL_COUNT) ? 0 : chan + 1;
        endfunction

        function void check_frame(logic [IDENT_W-1:0] ident, logic [DIST_W-1:0] even_dist,
                                  logic [DIST_W-1:0] odd_dist);
            frame_fields_t frame_exp;
            if (pending_frames.size() == 0)
            begin
                $error("frame with no frame expected: frame_ident %0d", ident);
                errors++;
                return;
            end
            frame_exp = pending_frames.pop_front();
            if (ident !== frame_exp.ident)
            begin
                $error("frame_ident: expected %0d, actual %0d", frame_exp.ident, ident);
                errors++;
            end
            if (even_dist !== frame_exp.even_dist)
            begin
                $error("even_distance: expected %0d, actual %0d", frame_exp.even_dist,
                       even_dist);
                errors++;
            end
            if (odd_dist !== frame_exp.odd_dist)
            begin
                $error("odd_distance: expected %0d, actual %0d", frame_exp.odd_dist, odd_dist);
                errors++;
            end
        endfunction

        function int frames_pending();
            return pending_frames.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   burst_left = 0;

    echo_frame_tracker tracker;

    emrf_in_if  echo_if ();
    emrf_out_if frame_if ();
    emrf_cfg_if cfg_if ();

    multichannel_echo_range_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .echo  (echo_if),
        .frame (frame_if),
        .cfg   (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. A hung handshake or a missing frame ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Every handshake is observed at the clock edge on the values that were
    // settled before it, so the order of processes within the step is moot.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                tracker.take_register(cfg_if.index, cfg_if.data);
            if (echo_if.valid && echo_if.ready)
                tracker.take_echo(echo_if.echo_width_us);
            if (frame_if.valid && frame_if.ready)
                tracker.check_frame(frame_if.frame_ident, frame_if.even_distance,
                                    frame_if.odd_distance);
        end
    end

    // The receiver switches between stall styles: always ready, coin flips, mostly
    // stalled, and a repeating pattern that drifts against the cadence of the back end.
    initial
    begin
        int mode;
        mode = 0;
        frame_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cycles % 48 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       frame_if.ready <= 1'b1;
                1:       frame_if.ready <= 1'($urandom_range(0, 1));
                2:       frame_if.ready <= ($urandom_range(0, 3) == 0);
                default: frame_if.ready <= ((cycles % 7) < 3);
            endcase
        end
    end

    // Sends one echo item. Items go out in bursts: a burst keeps valid high
    // from item to item, and a new burst starts after a gap with valid low,
    // so valid is never dropped and raised in the same step. Some bursts are
    // long enough to give stretches with no idling at all.
    task automatic send_echo(input logic [ECHO_W-1:0] width);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        echo_if.valid         <= 1'b1;
        echo_if.echo_width_us <= width;
        @(posedge clk);
        while (!echo_if.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left == 0)
            echo_if.valid <= 1'b0;
    endtask

    task automatic end_burst();
        if (burst_left != 0)
        begin
            echo_if.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic wait_frames_drained();
        while (tracker.frames_pending() != 0)
            @(posedge clk);
    endtask

    // Brings the block to rest: no item offered, every frame delivered and
    // enough cycles passed for any trailing even-channel item to finish.
    task automatic settle_block();
        end_burst();
        wait_frames_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back, then one write to an unmapped
    // index that the block must ignore. With junk set, the bits above each
    // register's width carry random values that the block must drop.
    task automatic apply_settings(input cfg_t setting, input bit junk);
        logic [CFG_INDEX_W-1:0] idx[5];
        logic [CFG_DATA_W-1:0]  val[5];
        logic [CFG_DATA_W-1:0]  upper;
        upper  = junk ? CFG_DATA_W'($urandom()) : '0;
        idx[0] = REG_BLEND_WEIGHT;
        val[0] = {upper[CFG_DATA_W-1:WEIGHT_W], setting.blend_weight};
        idx[1] = REG_RANGE_SCALE;
        val[1] = setting.range_scale;
        idx[2] = REG_NO_ECHO_DISTANCE;
        val[2] = {upper[CFG_DATA_W-1:DIST_W], setting.no_echo_distance};
        idx[3] = REG_NODE_NUMBER;
        val[3] = {upper[CFG_DATA_W-1:NODE_W], setting.node_number};
        idx[4] = FIRST_UNMAPPED_REG + CFG_INDEX_W'($urandom_range(0, 3));
        val[4] = CFG_DATA_W'($urandom());
        for (int i = 0; i < 5; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= val[i];
            @(posedge clk);
            while (!cfg_if.ready)
                @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Widths lean on the corners: no echo, the widest echo, tiny widths and
    // single set bits, with uniform values for the rest.
    function automatic logic [ECHO_W-1:0] random_width();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ECHO_MAX;
            2:       return ECHO_W'($urandom_range(1, 15));
            3:       return ECHO_W'(1) << $urandom_range(0, ECHO_W - 1);
            default: return ECHO_W'($urandom_range(0, ECHO_MAX));
        endcase
    endfunction

    // The first phases pin the extremes: everything at zero, full-weight
    // blending with the largest scale, a weight past one unit, and the reset
    // values. The rest are random.
    function automatic cfg_t phase_setting(input int phase);
        cfg_t setting;
        setting.blend_weight     = WEIGHT_W'($urandom_range(0, WEIGHT_MAX));
        setting.range_scale      = SCALE_W'($urandom());
        setting.no_echo_distance = DIST_W'($urandom_range(0, DIST_MAX));
        setting.node_number      = NODE_W'($urandom_range(0, NODE_MAX));
        case (phase)
            0:
            begin
                setting.blend_weight     = '0;
                setting.range_scale      = '0;
                setting.no_echo_distance = '0;
                setting.node_number      = '0;
            end
            1:
            begin
                setting.blend_weight     = WEIGHT_ONE;
                setting.range_scale      = SCALE_MAX;
                setting.no_echo_distance = DIST_MAX;
                setting.node_number      = NODE_MAX;
            end
            2:
            begin
                setting.blend_weight = WEIGHT_MAX;
            end
            3:
            begin
                setting.blend_weight     = RESET_WEIGHT;
                setting.range_scale      = RESET_SCALE;
                setting.no_echo_distance = RESET_NO_ECHO;
                setting.node_number      = RESET_NODE;
            end
            default: ;
        endcase
        return setting;
    endfunction

    initial
    begin
        // First sweep seeds every channel with the reset settings; the second
        // sweep blends into those seeds.
        logic [ECHO_W-1:0] seed_widths[20] = '{
            '0, ECHO_MAX, 14'd1, 14'd8192, 14'h2AAA, 14'h1555, 14'd8191, '0, ECHO_MAX, 14'd100,
            ECHO_MAX, '0, '0, ECHO_MAX, 14'd1, 14'd1, 14'd12345, 14'd4000, '0, ECHO_MAX
        };
        // With the largest scale the widest echoes saturate, and a weight past
        // one unit makes each new sample replace the average.
        logic [ECHO_W-1:0] corner_widths[4] = '{ECHO_MAX, 14'd1, '0, ECHO_MAX};
        cfg_t corner_setting;
        int   drain_point;

        rst_n                 <= 1'b0;
        echo_if.valid         <= 1'b0;
        echo_if.echo_width_us <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= REG_BLEND_WEIGHT;
        cfg_if.data           <= '0;
        tracker = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset settings.
        foreach (seed_widths[i])
            send_echo(seed_widths[i]);

        settle_block();
        corner_setting.blend_weight     = WEIGHT_W'(300);
        corner_setting.range_scale      = SCALE_MAX;
        corner_setting.no_echo_distance = DIST_MAX;
        corner_setting.node_number      = NODE_MAX;
        apply_settings(corner_setting, 1'b0);
        foreach (corner_widths[i])
            send_echo(corner_widths[i]);

        // Random phases. Once per phase, at a random point, the sender holds
        // off until every expected frame has come out.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle_block();
            apply_settings(phase_setting(phase), phase >= 2);
            drain_point = $urandom_range(10, PHASE_ITEMS - 10);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == drain_point)
                begin
                    end_burst();
                    wait_frames_drained();
                end
                send_echo(random_width());
            end
        end

        // Let the block run dry; any frame that shows up late is still checked.
        settle_block();

        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
